/* src/epoch_seconds_to_utc_date_assert.svh */
// Assertion macros for the epoch-to-UTC date converter.
// Included by epoch_seconds_to_utc_date, which carries concurrent checks; no dependencies.
`ifndef EPOCH_SECONDS_TO_UTC_DATE_ASSERT_SVH
`define EPOCH_SECONDS_TO_UTC_DATE_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define ESUD_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ESUD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/esud_pkg.sv */
// Shared constants for the epoch-to-UTC date pipeline: reciprocals for the
// constant divisions, calendar offsets and the month start table. No dependencies.
`default_nettype none

package esud_pkg;

    localparam int NSTG = 8;

    // n / 86400 = (n >> 7) / 675
    localparam int DAY_SHIFT = 7;
    localparam int DAY_ODD   = 675;
    localparam int DAY_K     = 35;
    localparam logic [25:0] DAY_RECIP =
        26'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    // rem / 3600 = (rem >> 4) / 225
    localparam int HOUR_ODD = 225;
    localparam int HOUR_K   = 21;
    localparam logic [13:0] HOUR_RECIP =
        14'(((64'd1 << HOUR_K) + 64'(HOUR_ODD) - 64'd1) / 64'(HOUR_ODD));
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;

    // rem / 60 = (rem >> 2) / 15
    localparam int MIN_ODD = 15;
    localparam int MIN_K   = 14;
    localparam logic [10:0] MIN_RECIP =
        11'(((64'd1 << MIN_K) + 64'(MIN_ODD) - 64'd1) / 64'(MIN_ODD));
    localparam logic [11:0] SECS_PER_MIN = 12'd60;

    localparam int WEEK_K = 19;
    localparam logic [16:0] WEEK_RECIP = 17'(((64'd1 << WEEK_K) + 64'd6) / 64'd7);
    localparam logic [15:0] EPOCH_WDAY = 16'd4;   // Jan 1 1970 was a Thursday

    // days counted from March 1 of 1 BC
    localparam logic [19:0] EPOCH_DAY = 20'(719527 - 59);
    localparam int DAYS_PER_400Y = 146097;
    localparam int Y400_K = 47;
    localparam logic [29:0] Y400_RECIP =
        30'(((64'd1 << Y400_K) + 64'(DAYS_PER_400Y) - 64'd1) / 64'(DAYS_PER_400Y));

    localparam int CENT_K = 19;
    localparam logic [12:0] CENT_RECIP = 13'(((64'd1 << CENT_K) + 64'd99) / 64'd100);

    // (yday + 31) * 10 / 306 = ((yday + 31) * 5) / 153
    localparam int MON_ODD = 153;
    localparam int MON_K   = 18;
    localparam logic [10:0] MON_RECIP =
        11'(((64'd1 << MON_K) + 64'(MON_ODD) - 64'd1) / 64'(MON_ODD));

    localparam logic [8:0] MARCH_YDAY_LIMIT = 9'd306;

    // floor(367 * m / 12) for the March-based month index
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd30;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd91;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd152;
            4'd6:    r = 9'd183;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd244;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd305;
            4'd11:   r = 9'd336;
            4'd12:   r = 9'd367;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/epoch_seconds_to_utc_date.sv */
// Converts a 32-bit Unix time beat into UTC second, minute, hour, day, month,
// year and weekday. Uses esud_pkg and epoch_seconds_to_utc_date_assert.svh.
//
// Usage:
//   Input channel s_valid/s_ready carries s_epoch_seconds, unsigned seconds
//   since 1970-01-01 00:00:00 UTC. Output channel m_valid/m_ready carries the
//   broken-down calendar fields, one result beat per input beat, in order.
//   Throughput is one beat per cycle: the work is split over 8 register
//   stages (constant reciprocal multiplies for the divisions), and a new
//   beat enters every cycle while the output is taken.
//   Each stage has its own valid bit and holds when the stage after it is
//   full and stalled, so a stall on m_ready backs up stage by stage; empty
//   stages still accept, nothing is dropped or repeated.
//   The last stage is the output register.
//   aresetn (synchronous, active low) empties the pipeline; s_ready is high
//   as soon as reset is released.
`default_nettype none
`include "epoch_seconds_to_utc_date_assert.svh"

module epoch_seconds_to_utc_date import esud_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_second,
    output logic [5:0]       m_minute,
    output logic [4:0]       m_hour,
    output logic [4:0]       m_day_of_month,
    output logic [3:0]       m_month,
    output logic [11:0]      m_year,
    output logic [2:0]       m_weekday
);

    logic [NSTG:1]   vld_reg;
    logic [NSTG+1:1] rdy;

    always_comb begin
        rdy[NSTG+1] = m_ready;
        for (int i = NSTG; i >= 1; i--) begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[1]) vld_reg[1] <= s_valid;
            for (int i = 2; i <= NSTG; i++) begin
                if (rdy[i]) vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = vld_reg[NSTG];

    // ---- stage 1: day count ----
    logic [50:0] p1_prod;
    logic [15:0] p1_days_next;
    logic [15:0] p1_days_reg;
    logic [31:0] p1_secs_reg;

    always_comb begin
        p1_prod      = 51'(s_epoch_seconds[31:DAY_SHIFT]) * 51'(DAY_RECIP);
        p1_days_next = p1_prod[DAY_K+15:DAY_K];
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            p1_days_reg <= p1_days_next;
            p1_secs_reg <= s_epoch_seconds;
        end
    end

    // ---- stage 2: second of day, shifted day count, year numerator, weekday offset ----
    logic [25:0] p2_dmul;
    logic [24:0] p2_rem_hi;
    logic [16:0] p2_rem_next;
    logic [19:0] p2_days2_next;
    logic [28:0] p2_num_next;
    logic [15:0] p2_dd_next;
    logic [16:0] p2_rem_reg;
    logic [19:0] p2_days2_reg;
    logic [28:0] p2_num_reg;
    logic [15:0] p2_dd_reg;

    always_comb begin
        p2_dmul       = 26'(p1_days_reg) * 26'(DAY_ODD);
        p2_rem_hi     = p1_secs_reg[31:DAY_SHIFT] - p2_dmul[24:0];
        p2_rem_next   = {p2_rem_hi[9:0], p1_secs_reg[DAY_SHIFT-1:0]};
        p2_days2_next = 20'(p1_days_reg) + EPOCH_DAY;
        p2_num_next   = 29'(p2_days2_next + 20'd2) * 29'd400;
        p2_dd_next    = p1_days_reg + EPOCH_WDAY;
    end

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            p2_rem_reg   <= p2_rem_next;
            p2_days2_reg <= p2_days2_next;
            p2_num_reg   <= p2_num_next;
            p2_dd_reg    <= p2_dd_next;
        end
    end

    // ---- stage 3: hour, year estimate, weekday quotient ----
    logic [26:0] p3_hprod;
    logic [58:0] p3_yprod;
    logic [32:0] p3_wprod;
    logic [4:0]  p3_hour_next;
    logic [11:0] p3_year_next;
    logic [13:0] p3_wq_next;
    logic [4:0]  p3_hour_reg;
    logic [11:0] p3_year_reg;
    logic [13:0] p3_wq_reg;
    logic [16:0] p3_rem_reg;
    logic [19:0] p3_days2_reg;
    logic [15:0] p3_dd_reg;

    always_comb begin
        p3_hprod     = 27'(p2_rem_reg[16:4]) * 27'(HOUR_RECIP);
        p3_hour_next = p3_hprod[HOUR_K+4:HOUR_K];
        p3_yprod     = 59'(p2_num_reg) * 59'(Y400_RECIP);
        p3_year_next = p3_yprod[Y400_K+11:Y400_K];
        p3_wprod     = 33'(p2_dd_reg) * 33'(WEEK_RECIP);
        p3_wq_next   = p3_wprod[WEEK_K+13:WEEK_K];
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            p3_hour_reg  <= p3_hour_next;
            p3_year_reg  <= p3_year_next;
            p3_wq_reg    <= p3_wq_next;
            p3_rem_reg   <= p2_rem_reg;
            p3_days2_reg <= p2_days2_reg;
            p3_dd_reg    <= p2_dd_reg;
        end
    end

    // ---- stage 4: second of hour, weekday, century ----
    logic [16:0] p4_hsecs;
    logic [16:0] p4_rem2_full;
    logic [16:0] p4_w7;
    logic [16:0] p4_wdiff;
    logic [24:0] p4_cprod;
    logic [11:0] p4_rem2_next;
    logic [2:0]  p4_wday_next;
    logic [5:0]  p4_cent_next;
    logic [11:0] p4_rem2_reg;
    logic [2:0]  p4_wday_reg;
    logic [5:0]  p4_cent_reg;
    logic [4:0]  p4_hour_reg;
    logic [11:0] p4_year_reg;
    logic [19:0] p4_days2_reg;

    always_comb begin
        p4_hsecs     = 17'(p3_hour_reg) * SECS_PER_HOUR;
        p4_rem2_full = p3_rem_reg - p4_hsecs;
        p4_rem2_next = p4_rem2_full[11:0];
        p4_w7        = 17'(p3_wq_reg) * 17'd7;
        p4_wdiff     = 17'(p3_dd_reg) - p4_w7;
        p4_wday_next = p4_wdiff[2:0];
        p4_cprod     = 25'(p3_year_reg) * 25'(CENT_RECIP);
        p4_cent_next = p4_cprod[CENT_K+5:CENT_K];
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            p4_rem2_reg  <= p4_rem2_next;
            p4_wday_reg  <= p4_wday_next;
            p4_cent_reg  <= p4_cent_next;
            p4_hour_reg  <= p3_hour_reg;
            p4_year_reg  <= p3_year_reg;
            p4_days2_reg <= p3_days2_reg;
        end
    end

    // ---- stage 5: minute, days before the estimated year, leap flag ----
    logic [20:0] p5_mprod;
    logic [5:0]  p5_min_next;
    logic [19:0] p5_dcount_next;
    logic [11:0] p5_ymod100;
    logic        p5_leap_next;
    logic [5:0]  p5_min_reg;
    logic [19:0] p5_dcount_reg;
    logic        p5_leap_reg;
    logic [11:0] p5_rem2_reg;
    logic [2:0]  p5_wday_reg;
    logic [4:0]  p5_hour_reg;
    logic [11:0] p5_year_reg;
    logic [19:0] p5_days2_reg;

    always_comb begin
        p5_mprod       = 21'(p4_rem2_reg[11:2]) * 21'(MIN_RECIP);
        p5_min_next    = p5_mprod[MIN_K+5:MIN_K];
        p5_dcount_next = 20'(p4_year_reg) * 20'd365 + 20'(p4_year_reg[11:2])
                         - 20'(p4_cent_reg) + 20'(p4_cent_reg[5:2]);
        p5_ymod100     = p4_year_reg - 12'(p4_cent_reg) * 12'd100;
        // divisible by 400 when the year is a whole century and the century by 4
        p5_leap_next   = (p4_year_reg[1:0] == 2'd0)
                         && ((p5_ymod100 != 12'd0) || (p4_cent_reg[1:0] == 2'd0));
    end

    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            p5_min_reg    <= p5_min_next;
            p5_dcount_reg <= p5_dcount_next;
            p5_leap_reg   <= p5_leap_next;
            p5_rem2_reg   <= p4_rem2_reg;
            p5_wday_reg   <= p4_wday_reg;
            p5_hour_reg   <= p4_hour_reg;
            p5_year_reg   <= p4_year_reg;
            p5_days2_reg  <= p4_days2_reg;
        end
    end

    // ---- stage 6: second, March-based day of year ----
    logic [11:0] p6_msecs;
    logic [11:0] p6_sdiff;
    logic [5:0]  p6_sec_next;
    logic [20:0] p6_diff;
    logic [20:0] p6_fix;
    logic [8:0]  p6_yday_next;
    logic [11:0] p6_year_next;
    logic [5:0]  p6_sec_reg;
    logic [8:0]  p6_yday_reg;
    logic [11:0] p6_year_reg;
    logic [5:0]  p6_min_reg;
    logic [4:0]  p6_hour_reg;
    logic [2:0]  p6_wday_reg;

    always_comb begin
        p6_msecs    = 12'(p5_min_reg) * SECS_PER_MIN;
        p6_sdiff    = p5_rem2_reg - p6_msecs;
        p6_sec_next = p6_sdiff[5:0];
        p6_diff     = 21'(p5_days2_reg) - 21'(p5_dcount_reg);
        p6_fix      = p6_diff + 21'd365 + 21'(p5_leap_reg);
        // estimate overshot: back up one year
        if (p6_diff[20]) begin
            p6_yday_next = p6_fix[8:0];
            p6_year_next = p5_year_reg - 12'd1;
        end else begin
            p6_yday_next = p6_diff[8:0];
            p6_year_next = p5_year_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[6]) begin
            p6_sec_reg  <= p6_sec_next;
            p6_yday_reg <= p6_yday_next;
            p6_year_reg <= p6_year_next;
            p6_min_reg  <= p5_min_reg;
            p6_hour_reg <= p5_hour_reg;
            p6_wday_reg <= p5_wday_reg;
        end
    end

    // ---- stage 7: March-based month ----
    logic [10:0] p7_mv;
    logic [21:0] p7_mprod;
    logic [3:0]  p7_mon_next;
    logic [3:0]  p7_mon_reg;
    logic [8:0]  p7_yday_reg;
    logic [11:0] p7_year_reg;
    logic [5:0]  p7_sec_reg;
    logic [5:0]  p7_min_reg;
    logic [4:0]  p7_hour_reg;
    logic [2:0]  p7_wday_reg;

    always_comb begin
        p7_mv       = (11'(p6_yday_reg) + 11'd31) * 11'd5;
        p7_mprod    = 22'(p7_mv) * 22'(MON_RECIP);
        p7_mon_next = p7_mprod[MON_K+3:MON_K];
    end

    always_ff @(posedge aclk) begin
        if (rdy[7]) begin
            p7_mon_reg  <= p7_mon_next;
            p7_yday_reg <= p6_yday_reg;
            p7_year_reg <= p6_year_reg;
            p7_sec_reg  <= p6_sec_reg;
            p7_min_reg  <= p6_min_reg;
            p7_hour_reg <= p6_hour_reg;
            p7_wday_reg <= p6_wday_reg;
        end
    end

    // ---- stage 8: day of month, calendar month and year (output register) ----
    logic [9:0]  p8_mday_full;
    logic [4:0]  p8_mday_next;
    logic [3:0]  p8_mon_next;
    logic [11:0] p8_year_next;
    logic [4:0]  p8_mday_reg;
    logic [3:0]  p8_mon_reg;
    logic [11:0] p8_year_reg;
    logic [5:0]  p8_sec_reg;
    logic [5:0]  p8_min_reg;
    logic [4:0]  p8_hour_reg;
    logic [2:0]  p8_wday_reg;

    always_comb begin
        p8_mday_full = 10'(p7_yday_reg) + 10'd31 - 10'(month_start(p7_mon_reg));
        p8_mday_next = p8_mday_full[4:0];
        // January and February belong to the next calendar year
        if (p7_yday_reg >= MARCH_YDAY_LIMIT) begin
            p8_mon_next  = p7_mon_reg - 4'd10;
            p8_year_next = p7_year_reg + 12'd1;
        end else begin
            p8_mon_next  = p7_mon_reg + 4'd2;
            p8_year_next = p7_year_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[8]) begin
            p8_mday_reg <= p8_mday_next;
            p8_mon_reg  <= p8_mon_next;
            p8_year_reg <= p8_year_next;
            p8_sec_reg  <= p7_sec_reg;
            p8_min_reg  <= p7_min_reg;
            p8_hour_reg <= p7_hour_reg;
            p8_wday_reg <= p7_wday_reg;
        end
    end

    assign m_second       = p8_sec_reg;
    assign m_minute       = p8_min_reg;
    assign m_hour         = p8_hour_reg;
    assign m_day_of_month = p8_mday_reg;
    assign m_month        = p8_mon_reg;
    assign m_year         = p8_year_reg;
    assign m_weekday      = p8_wday_reg;

    // ---- checks ----
    `ESUD_ASSERT_IMPL(a_ready_when_drained, aclk, aresetn, (!vld_reg[NSTG] || m_ready), s_ready, "input not ready although output side can move")
    `ESUD_ASSERT_NEXT(a_accept_fills_first, aclk, aresetn, (s_valid && s_ready), vld_reg[1], "accepted beat missing from first stage")
    `ESUD_ASSERT_IMPL(a_time_range, aclk, aresetn, m_valid, (m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59), "time of day out of range")
    `ESUD_ASSERT_IMPL(a_date_range, aclk, aresetn, m_valid, (m_month >= 4'd1 && m_month <= 4'd12 && m_day_of_month != 5'd0 && m_weekday <= 3'd6), "date field out of range")

endmodule

`default_nettype wire
